// ----- src/sbtc_pkg.sv -----
// Shared types, constants and helpers for the six-bit text codec.
package sbtc_pkg;

    localparam int MAX_LINE_BYTES = 60;
    localparam int MAX_LINE_CHARS = 80;
    localparam int RUN_W          = $clog2(MAX_LINE_CHARS + 1);
    localparam int BURST_MAX      = 4;
    localparam int COUNT_W        = $clog2(BURST_MAX + 1);

    localparam logic [7:0] CHAR_OFFSET = 8'd33;
    localparam logic [7:0] DEC_ADJUST  = 8'd31;   // 64 - 33, keeps the subtraction positive

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       overrun;
    } out_word_t;

    typedef struct packed {
        out_word_t [BURST_MAX-1:0] word;
        logic      [COUNT_W-1:0]   count;
    } burst_t;

    function automatic logic [7:0] enc_char(input logic [5:0] slice);
        enc_char = {2'b00, slice} + CHAR_OFFSET;
    endfunction

endpackage

// ----- src/sbtc_core.sv -----
// Group assembly, line limit tracking and result burst formation.
module sbtc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_mode,
    input  logic              accept,
    input  sbtc_pkg::in_word_t item,
    output sbtc_pkg::burst_t   burst
);
    import sbtc_pkg::*;

    logic             mode_reg;
    logic [23:0]      bits_reg,  bits_next;
    logic [1:0]       pos_reg,   pos_next;
    logic [RUN_W-1:0] run_reg,   run_next;
    logic             ovr_reg,   ovr_next;

    logic [RUN_W-1:0] limit;
    logic [RUN_W-1:0] run_inc;
    logic [23:0]      bits_new;
    logic [1:0]       enc_pos;
    logic [5:0]       dec_val;
    logic [7:0]       dec_sum;
    logic [COUNT_W-1:0] n;

    assign limit   = (mode_reg == MODE_DECODE) ? RUN_W'(MAX_LINE_CHARS) : RUN_W'(MAX_LINE_BYTES);
    assign run_inc = run_reg + RUN_W'(1);
    assign enc_pos = (pos_reg == 2'd3) ? 2'd2 : pos_reg;
    assign dec_sum = item.data_in + DEC_ADJUST;
    assign dec_val = dec_sum[5:0];

    always_comb
    begin
        bits_next = bits_reg;
        pos_next  = pos_reg;
        run_next  = run_reg;
        ovr_next  = ovr_reg;
        bits_new  = bits_reg;
        n         = '0;
        burst     = '0;

        if (ovr_reg || (run_reg >= limit))
        begin
            // Beyond the line limit: drop the open group, report once at the end.
            ovr_next  = 1'b1;
            bits_next = '0;
            pos_next  = '0;
            if (item.last_in)
            begin
                n = COUNT_W'(1);
                burst.word[0] = '{data_out: 8'd0, last_out: 1'b1, overrun: 1'b1};
            end
        end
        else
        begin
            run_next = run_inc;
            if (mode_reg == MODE_ENCODE)
            begin
                unique case (enc_pos)
                    2'd0:    bits_new = bits_reg | {item.data_in, 16'h0};
                    2'd1:    bits_new = bits_reg | {8'h0, item.data_in, 8'h0};
                    default: bits_new = bits_reg | {16'h0, item.data_in};
                endcase
                bits_next = bits_new;
                pos_next  = enc_pos + 2'd1;
                if ((enc_pos == 2'd2) || item.last_in)
                begin
                    n = (enc_pos == 2'd2) ? COUNT_W'(4) : COUNT_W'(enc_pos) + COUNT_W'(2);
                    burst.word[0].data_out = enc_char(bits_new[23:18]);
                    burst.word[1].data_out = enc_char(bits_new[17:12]);
                    burst.word[2].data_out = enc_char(bits_new[11:6]);
                    burst.word[3].data_out = enc_char(bits_new[5:0]);
                    bits_next = '0;
                    pos_next  = '0;
                end
            end
            else
            begin
                unique case (pos_reg)
                    2'd0:    bits_new = bits_reg | {dec_val, 18'h0};
                    2'd1:    bits_new = bits_reg | {6'h0, dec_val, 12'h0};
                    2'd2:    bits_new = bits_reg | {12'h0, dec_val, 6'h0};
                    default: bits_new = bits_reg | {18'h0, dec_val};
                endcase
                bits_next = bits_new;
                pos_next  = pos_reg + 2'd1;
                if ((pos_reg == 2'd3) || item.last_in)
                begin
                    n = COUNT_W'(3);
                    if (item.last_in && (run_inc != RUN_W'(MAX_LINE_CHARS)))
                        n = (bits_new[15:0] == 16'h0) ? COUNT_W'(1) : COUNT_W'(2);
                    burst.word[0].data_out = bits_new[23:16];
                    burst.word[1].data_out = bits_new[15:8];
                    burst.word[2].data_out = bits_new[7:0];
                    bits_next = '0;
                    pos_next  = '0;
                end
            end
            // Mark the final word of the run.
            for (int i = 0; i < BURST_MAX; i++)
                burst.word[i].last_out = item.last_in && (COUNT_W'(i + 1) == n);
        end

        if (item.last_in)
        begin
            bits_next = '0;
            pos_next  = '0;
            run_next  = '0;
            ovr_next  = 1'b0;
        end
        burst.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
            bits_reg <= '0;
            pos_reg  <= '0;
            run_reg  <= '0;
            ovr_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_mode;
            bits_reg <= '0;
            pos_reg  <= '0;
            run_reg  <= '0;
            ovr_reg  <= 1'b0;
        end
        else if (accept)
        begin
            bits_reg <= bits_next;
            pos_reg  <= pos_next;
            run_reg  <= run_next;
            ovr_reg  <= ovr_next;
        end
    end

endmodule

// ----- src/sbtc_drain.sv -----
// Result buffer that holds one burst and hands it out a word per cycle while out_ready is high.
module sbtc_drain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sbtc_pkg::burst_t    burst,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output sbtc_pkg::out_word_t out_data
);
    import sbtc_pkg::*;

    out_word_t [BURST_MAX-1:0] words_reg;
    logic      [COUNT_W-1:0]   count_reg;
    logic                      pop;
    logic                      fill;

    assign out_valid = (count_reg != '0);
    assign out_data  = words_reg[0];
    assign pop       = out_valid && out_ready;
    assign space     = (count_reg == '0) || ((count_reg == COUNT_W'(1)) && out_ready);
    assign fill      = load && (burst.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (fill)
            count_reg <= burst.count;
        else if (pop)
            count_reg <= count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (fill)
            words_reg <= burst.word;
        else if (pop)
        begin
            // advance the queue towards the head
            for (int i = 0; i < BURST_MAX - 1; i++)
                words_reg[i] <= words_reg[i+1];
        end
    end

endmodule

// ----- src/six_bit_text_codec_top.sv -----
// Top level of the six-bit text codec: input handshake, core and result buffer.
// The first result word of an input word is presented right after the edge that accepts
// it. Result words leave one per cycle while out_ready is high; a new input word is
// taken while the result buffer is empty or handing out its final word.
// Reset: mode returns to encode, the run state clears and the result buffer empties.
module six_bit_text_codec_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sbtc_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sbtc_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import sbtc_pkg::*;

    burst_t burst;
    logic   space;
    logic   accept;

    // Mode writes must arrive only while idle; the block does not enforce this and takes them at once.
    assign cfg_ready = 1'b1;

    // Hold input off unless the result buffer is empty or its last word is leaving.
    assign in_ready = space;
    assign accept   = in_valid && in_ready;

    // Assemble the group and form the burst of result words in one pass.
    sbtc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_mode (cfg_data),
        .accept   (accept),
        .item     (in_data),
        .burst    (burst)
    );

    // Register the burst and drop one word per accepted output handshake.
    sbtc_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .burst     (burst),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- src/sbtc_checker.sv -----
// Port-level checks for the six-bit text codec, bound to the top level.
module sbtc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input sbtc_pkg::out_word_t out_data
);
    import sbtc_pkg::*;

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // An overrun report is a lone zero word closing the run.
    a_ovr_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overrun |-> out_data.last_out && (out_data.data_out == 8'd0))
        else $error("malformed overrun word");

    // With nothing pending the input side must be open.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result buffer");

    // The last word of a run leaves an empty buffer unless a new burst was loaded.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_out |-> in_ready)
        else $error("input blocked while final word leaves");

endmodule

bind six_bit_text_codec_top sbtc_checker u_sbtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- sim/tb_six_bit_text_codec_top.sv -----
// Self-checking bench for the six-bit text codec: line runs in both modes against a predictor.
module tb_six_bit_text_codec_top;
    import sbtc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 4;       // first result shows right after the accepting edge
    localparam int PHASE_WORDS    = 6;       // least number of random-line words per phase after its long line
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam logic [15:0] STALL_PATTERN = 16'b1011_0111_0011_1101;

    // Mirror of the codec: tracks the open group and line, and queues the words it must emit.
    class codec_mirror;
        logic        mode;
        logic [23:0] group_bits;
        int          group_fill;
        int          line_count;
        bit          line_overrun;
        out_word_t   due_words[$];
        int          mismatches;
        int          checked;
        int          overrun_lines;

        function new();
            mode          = MODE_ENCODE;
            mismatches    = 0;
            checked       = 0;
            overrun_lines = 0;
            clear_line();
        endfunction

        function void clear_line();
            group_bits   = '0;
            group_fill   = 0;
            line_count   = 0;
            line_overrun = 1'b0;
        endfunction

        function void set_mode(logic m);
            mode = m;
            clear_line();
        endfunction

        function int outstanding();
            return due_words.size();
        endfunction

        function void queue_word(logic [7:0] data, logic last, logic ovr);
            out_word_t w;
            w.data_out = data;
            w.last_out = last;
            w.overrun  = ovr;
            due_words.push_back(w);
        endfunction

        // Note one accepted input word and queue whatever it releases.
        function void absorb_word(in_word_t w);
            int         limit;
            int         n;
            logic [7:0] shifted;
            logic [5:0] sextet;
            limit = (mode == MODE_DECODE) ? MAX_LINE_CHARS : MAX_LINE_BYTES;
            if (line_overrun || line_count >= limit) begin
                // past the limit: drop the open group, report once on the final word
                line_overrun = 1'b1;
                group_bits   = '0;
                group_fill   = 0;
                if (w.last_in) begin
                    queue_word(8'd0, 1'b1, 1'b1);
                    clear_line();
                end
                return;
            end
            line_count++;
            if (mode == MODE_ENCODE) begin
                group_bits = group_bits | (24'(w.data_in) << (16 - 8 * group_fill));
                group_fill++;
                if (group_fill == 3 || w.last_in) begin
                    n = (group_fill == 3) ? 4 : group_fill + 1;
                    for (int i = 0; i < n; i++) begin
                        sextet = group_bits[23 - 6 * i -: 6];
                        queue_word({2'b00, sextet} + CHAR_OFFSET, w.last_in && i == n - 1, 1'b0);
                    end
                    group_bits = '0;
                    group_fill = 0;
                end
            end
            else begin
                shifted    = w.data_in - CHAR_OFFSET;
                group_bits = group_bits | (24'(shifted[5:0]) << (18 - 6 * group_fill));
                group_fill++;
                if (group_fill == 4 || w.last_in) begin
                    n = 3;
                    if (w.last_in && line_count != MAX_LINE_CHARS)
                        n = (group_bits[15:0] == 16'd0) ? 1 : 2;
                    for (int i = 0; i < n; i++)
                        queue_word(group_bits[23 - 8 * i -: 8], w.last_in && i == n - 1, 1'b0);
                    group_bits = '0;
                    group_fill = 0;
                end
            end
            if (w.last_in)
                clear_line();
        endfunction

        // Compare one accepted result word with the oldest queued word.
        function void match_word(out_word_t got);
            out_word_t want;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: data %02h last %0b overrun %0b",
                             got.data_out, got.last_out, got.overrun);
                return;
            end
            want = due_words.pop_front();
            checked++;
            if (want.overrun)
                overrun_lines++;
            if (got.data_out !== want.data_out || got.last_out !== want.last_out ||
                got.overrun !== want.overrun) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result word %0d: expected data %02h last %0b overrun %0b, got data %02h last %0b overrun %0b",
                             checked, want.data_out, want.last_out, want.overrun,
                             got.data_out, got.last_out, got.overrun);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    codec_mirror mirror = new();

    int burst_left    = 0;
    bit sender_steady = 1'b0;
    int words_sent    = 0;
    int encode_words  = 0;
    int decode_words  = 0;
    int mode_writes   = 0;
    int rx_cycle      = 0;

    six_bit_text_codec_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Sender pacing: bursts of random length, random gaps between them; none in steady phases.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0 || sender_steady) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Offer one word and hold it until the codec takes it.
    task automatic send_word(in_word_t w);
        pace_sender();
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        mirror.absorb_word(w);
        words_sent++;
        if (mirror.mode == MODE_DECODE)
            decode_words++;
        else
            encode_words++;
    endtask

    // Encode: raw bytes with extra weight on all-zero and all-one bytes.
    // Decode: mostly alphabet characters, a good share of zero-value '!', some arbitrary codes.
    function automatic logic [7:0] pick_data();
        int r;
        if (mirror.mode == MODE_ENCODE) begin
            r = $urandom_range(0, 7);
            if (r == 0)
                return 8'h00;
            if (r == 1)
                return 8'hFF;
            return 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 15);
        if (r < 10)
            return 8'($urandom_range(33, 96));
        if (r < 13)
            return CHAR_OFFSET;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly short lines, now and then a long one, one at or just under the limit or one that overruns.
    function automatic int pick_line_length();
        int limit;
        int r;
        limit = (mirror.mode == MODE_DECODE) ? MAX_LINE_CHARS : MAX_LINE_BYTES;
        r = $urandom_range(0, 63);
        if (r < 58)
            return $urandom_range(1, 12);
        if (r < 60)
            return $urandom_range(13, limit - 3);
        if (r < 62)
            return $urandom_range(limit - 2, limit);
        return $urandom_range(limit + 1, limit + 3);
    endfunction

    task automatic send_line(int len, bit close);
        in_word_t w;
        for (int i = 0; i < len; i++) begin
            w.data_in = pick_data();
            w.last_in = close && (i == len - 1);
            send_word(w);
        end
    endtask

    // Hold the input until every queued word has arrived, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the mode register only once the codec has gone quiet.
    task automatic write_mode(logic m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror.set_mode(m);
        mode_writes++;
    endtask

    // One phase: an optional long line, then random lines, sometimes one left open.
    task automatic run_phase(int long_len, bit steady);
        int start;
        sender_steady = steady;
        if (long_len > 0)
            send_line(long_len, 1'b1);
        start = words_sent;
        while (words_sent - start < PHASE_WORDS)
            send_line(pick_line_length(), 1'b1);
        // leave a partial group open so that the next mode write must discard it
        if ($urandom_range(0, 1) == 1)
            send_line($urandom_range(1, 5), 1'b0);
    endtask

    // Main sequence.
    initial
    begin
        in_word_t encode_cases[10];
        in_word_t decode_cases[16];
        // encode tails of one and two bytes, a full final group, a full group plus a tail
        encode_cases = '{'{8'h00, 1'b1},
                         '{8'hFF, 1'b0}, '{8'hFF, 1'b1},
                         '{8'hFF, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b1},
                         '{8'hAA, 1'b0}, '{8'h55, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b1}};
        // decode: lone zero character, codes outside the alphabet, full group then a tail,
        // full final group with zero low bits, three-character tail
        decode_cases = '{'{8'h21, 1'b1},
                         '{8'h00, 1'b0}, '{8'hFF, 1'b1},
                         '{8'h60, 1'b0}, '{8'h60, 1'b0}, '{8'h60, 1'b0}, '{8'h60, 1'b0},
                         '{8'h21, 1'b0}, '{8'h22, 1'b1},
                         '{8'h21, 1'b0}, '{8'h21, 1'b0}, '{8'h21, 1'b0}, '{8'h21, 1'b1},
                         '{8'h41, 1'b0}, '{8'h42, 1'b0}, '{8'h43, 1'b1}};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_steady = 1'b1;
        foreach (encode_cases[i])
            send_word(encode_cases[i]);
        drain_results();
        run_phase(MAX_LINE_BYTES + 1, 1'b0);        // encode overrun

        write_mode(MODE_DECODE);
        sender_steady = 1'b0;
        foreach (decode_cases[i])
            send_word(decode_cases[i]);
        run_phase(MAX_LINE_CHARS, 1'b1);            // exactly full line, no trim

        write_mode(MODE_DECODE);                    // same value again still clears the line
        run_phase(MAX_LINE_CHARS + 1, 1'b0);        // decode overrun
        write_mode(MODE_ENCODE);
        run_phase(0, 1'b0);
        write_mode(MODE_DECODE);
        run_phase(0, 1'b1);
        write_mode(MODE_ENCODE);
        run_phase(0, 1'b0);

        drain_results();
        $display("run covered %0d input words (%0d encode, %0d decode) over %0d mode writes",
                 words_sent, encode_words, decode_words, mode_writes);
        $display("%0d result words checked, %0d overrun lines, %0d mismatches",
                 mirror.checked, mirror.overrun_lines, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: check each accepted word, then choose the next ready on a rotating scheme.
    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                mirror.match_word(out_data);
            rx_cycle++;
            case ((rx_cycle / 160) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= STALL_PATTERN[rx_cycle % 16];
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog: stop a hung run.
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
